// ===== hdl/qvr_pkg.sv =====
// ----------------------------------------------------------------------------
// qvr_pkg: shared types and constants for the quaternion vector rotator
// Holds the input and result beat structs and the datapath widths.
// ----------------------------------------------------------------------------
package qvr_pkg;

  // Width of every input field and of each output vector component.
  localparam int FW = 16;
  // Width of q*p parts (sum of three 16x16 products, signed).
  localparam int TW = 33;
  // Width of |q|^2 (sum of four squares, unsigned).
  localparam int DW = 33;
  // Width of one t*conj(q) product, signed.
  localparam int PW = TW + FW;
  // Width of the q*p*conj(q) vector parts (sum of four products, signed).
  localparam int RW = PW + 1;
  // Quotient magnitude bits: |r| / |q|^2 equals |v|, which stays below 2^17.
  localparam int QW = 17;
  // One divider stage per quotient bit.
  localparam int DIV_STAGES = QW;
  // Cycles from an accepted start to the result strobe.
  localparam int LATENCY = DIV_STAGES + 4;

  // Saturation bounds for the 16-bit results.
  localparam logic [QW-1:0] MAG_POS_MAX = QW'(32767);
  localparam logic [QW-1:0] MAG_NEG_MAX = QW'(32768);

  typedef struct packed {
    logic signed [FW-1:0] quat_w;
    logic signed [FW-1:0] quat_x;
    logic signed [FW-1:0] quat_y;
    logic signed [FW-1:0] quat_z;
    logic signed [FW-1:0] vec_x;
    logic signed [FW-1:0] vec_y;
    logic signed [FW-1:0] vec_z;
  } qvr_in_t;

  typedef struct packed {
    logic signed [FW-1:0] rot_x;
    logic signed [FW-1:0] rot_y;
    logic signed [FW-1:0] rot_z;
    logic                 zero_quat;
    logic                 saturated;
  } qvr_out_t;

endpackage

// ===== hdl/quaternion_vector_rotate.sv =====
// ----------------------------------------------------------------------------
// quaternion_vector_rotate: rotate a vector by q * (0, v) * conj(q) / |q|^2
// Products run over three stages, then a restoring divider gives one
// quotient bit per stage, and a last stage applies sign and saturation.
// ----------------------------------------------------------------------------
// Throughput: one beat per cycle; busy is always low.
// The depth is set by the 17-stage divider, one quotient bit per stage.
// Reset clears all valid bits; data registers are not reset.
// The receiver cannot stall, so no result is ever held back.
module quaternion_vector_rotate import qvr_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  qvr_in_t  in_data,
  output logic     out_valid,
  output qvr_out_t out_data
);

  // The pipeline takes a beat every cycle.
  assign busy = 1'b0;

  logic accept;
  assign accept = start & ~busy;

  // --------------------------------------------------------------------------
  // Stage 1: t = q * p and |q|^2
  // --------------------------------------------------------------------------
  logic signed [2*FW-1:0] p_wx, p_wy, p_wz, p_xx, p_xy, p_xz;
  logic signed [2*FW-1:0] p_yx, p_yy, p_yz, p_zx, p_zy, p_zz;
  logic signed [2*FW-1:0] sq_w, sq_x, sq_y, sq_z;

  assign p_wx = in_data.quat_w * in_data.vec_x;
  assign p_wy = in_data.quat_w * in_data.vec_y;
  assign p_wz = in_data.quat_w * in_data.vec_z;
  assign p_xx = in_data.quat_x * in_data.vec_x;
  assign p_xy = in_data.quat_x * in_data.vec_y;
  assign p_xz = in_data.quat_x * in_data.vec_z;
  assign p_yx = in_data.quat_y * in_data.vec_x;
  assign p_yy = in_data.quat_y * in_data.vec_y;
  assign p_yz = in_data.quat_y * in_data.vec_z;
  assign p_zx = in_data.quat_z * in_data.vec_x;
  assign p_zy = in_data.quat_z * in_data.vec_y;
  assign p_zz = in_data.quat_z * in_data.vec_z;
  assign sq_w = in_data.quat_w * in_data.quat_w;
  assign sq_x = in_data.quat_x * in_data.quat_x;
  assign sq_y = in_data.quat_y * in_data.quat_y;
  assign sq_z = in_data.quat_z * in_data.quat_z;

  logic signed [TW-1:0] s1_tw_nxt, s1_tx_nxt, s1_ty_nxt, s1_tz_nxt;
  logic [DW-1:0]        s1_den_nxt;

  assign s1_tw_nxt = -TW'(p_xx) - TW'(p_yy) - TW'(p_zz);
  assign s1_tx_nxt =  TW'(p_wx) + TW'(p_yz) - TW'(p_zy);
  assign s1_ty_nxt =  TW'(p_wy) - TW'(p_xz) + TW'(p_zx);
  assign s1_tz_nxt =  TW'(p_wz) + TW'(p_xy) - TW'(p_yx);
  assign s1_den_nxt = DW'($unsigned(sq_w)) + DW'($unsigned(sq_x))
                    + DW'($unsigned(sq_y)) + DW'($unsigned(sq_z));

  logic                 s1_vld_r;
  logic signed [TW-1:0] s1_tw_r, s1_tx_r, s1_ty_r, s1_tz_r;
  logic signed [FW-1:0] s1_qw_r, s1_qx_r, s1_qy_r, s1_qz_r;
  logic [DW-1:0]        s1_den_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    s1_tw_r  <= s1_tw_nxt;
    s1_tx_r  <= s1_tx_nxt;
    s1_ty_r  <= s1_ty_nxt;
    s1_tz_r  <= s1_tz_nxt;
    s1_den_r <= s1_den_nxt;
    s1_qw_r  <= in_data.quat_w;
    s1_qx_r  <= in_data.quat_x;
    s1_qy_r  <= in_data.quat_y;
    s1_qz_r  <= in_data.quat_z;
  end

  // --------------------------------------------------------------------------
  // Stage 2: the twelve products of t * conj(q) that feed the vector part
  // --------------------------------------------------------------------------
  logic                 s2_vld_r;
  logic [DW-1:0]        s2_den_r;
  logic signed [PW-1:0] s2_wx_r, s2_wy_r, s2_wz_r;
  logic signed [PW-1:0] s2_xw_r, s2_xy_r, s2_xz_r;
  logic signed [PW-1:0] s2_yw_r, s2_yx_r, s2_yz_r;
  logic signed [PW-1:0] s2_zw_r, s2_zx_r, s2_zy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_den_r <= s1_den_r;
    s2_wx_r  <= s1_tw_r * s1_qx_r;
    s2_wy_r  <= s1_tw_r * s1_qy_r;
    s2_wz_r  <= s1_tw_r * s1_qz_r;
    s2_xw_r  <= s1_tx_r * s1_qw_r;
    s2_xy_r  <= s1_tx_r * s1_qy_r;
    s2_xz_r  <= s1_tx_r * s1_qz_r;
    s2_yw_r  <= s1_ty_r * s1_qw_r;
    s2_yx_r  <= s1_ty_r * s1_qx_r;
    s2_yz_r  <= s1_ty_r * s1_qz_r;
    s2_zw_r  <= s1_tz_r * s1_qw_r;
    s2_zx_r  <= s1_tz_r * s1_qx_r;
    s2_zy_r  <= s1_tz_r * s1_qy_r;
  end

  // --------------------------------------------------------------------------
  // Stage 3: sum to r, split into sign and magnitude for the divider
  // --------------------------------------------------------------------------
  logic signed [RW-1:0] s3_r [3];

  assign s3_r[0] = -RW'(s2_wx_r) + RW'(s2_xw_r) - RW'(s2_yz_r) + RW'(s2_zy_r);
  assign s3_r[1] = -RW'(s2_wy_r) + RW'(s2_xz_r) + RW'(s2_yw_r) - RW'(s2_zx_r);
  assign s3_r[2] = -RW'(s2_wz_r) - RW'(s2_xy_r) + RW'(s2_yx_r) + RW'(s2_zw_r);

  // Divider pipeline registers; index 0 is loaded here.
  logic          dv_vld_r [DIV_STAGES+1];
  logic [DW-1:0] dv_den_r [DIV_STAGES+1];
  logic          dv_zq_r  [DIV_STAGES+1];
  logic [RW-1:0] dv_rem_r [DIV_STAGES+1][3];
  logic [QW-1:0] dv_quo_r [DIV_STAGES+1][3];
  logic          dv_neg_r [DIV_STAGES+1][3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_vld_r[0] <= 1'b0;
    end else begin
      dv_vld_r[0] <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    dv_den_r[0] <= s2_den_r;
    dv_zq_r[0]  <= (s2_den_r == '0);
    for (int c = 0; c < 3; c++) begin
      dv_neg_r[0][c] <= s3_r[c][RW-1];
      dv_rem_r[0][c] <= s3_r[c][RW-1] ? RW'(-s3_r[c]) : RW'(s3_r[c]);
      dv_quo_r[0][c] <= '0;
    end
  end

  // --------------------------------------------------------------------------
  // Restoring divider: stage g decides quotient bit DIV_STAGES-1-g
  // --------------------------------------------------------------------------
  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    localparam int SH = DIV_STAGES - 1 - g;

    logic [RW-1:0] dsh;
    logic [RW-1:0] rem_nxt [3];
    logic [QW-1:0] quo_nxt [3];

    assign dsh = RW'(dv_den_r[g]) << SH;

    // Compare and subtract for each component.
    always_comb begin
      for (int c = 0; c < 3; c++) begin
        if (dv_rem_r[g][c] >= dsh) begin
          rem_nxt[c] = dv_rem_r[g][c] - dsh;
          quo_nxt[c] = {dv_quo_r[g][c][QW-2:0], 1'b1};
        end else begin
          rem_nxt[c] = dv_rem_r[g][c];
          quo_nxt[c] = {dv_quo_r[g][c][QW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_vld_r[g+1] <= 1'b0;
      end else begin
        dv_vld_r[g+1] <= dv_vld_r[g];
      end
    end

    always_ff @(posedge clk) begin
      dv_den_r[g+1] <= dv_den_r[g];
      dv_zq_r[g+1]  <= dv_zq_r[g];
      for (int c = 0; c < 3; c++) begin
        dv_rem_r[g+1][c] <= rem_nxt[c];
        dv_quo_r[g+1][c] <= quo_nxt[c];
        dv_neg_r[g+1][c] <= dv_neg_r[g][c];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output stage: restore sign, saturate, handle the zero quaternion
  // --------------------------------------------------------------------------
  logic [FW-1:0] rot_nxt [3];
  logic [2:0]    clip;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      if (dv_neg_r[DIV_STAGES][c]) begin
        clip[c]    = dv_quo_r[DIV_STAGES][c] > MAG_NEG_MAX;
        rot_nxt[c] = clip[c] ? FW'(MAG_NEG_MAX)
                             : FW'(-dv_quo_r[DIV_STAGES][c]);
      end else begin
        clip[c]    = dv_quo_r[DIV_STAGES][c] > MAG_POS_MAX;
        rot_nxt[c] = clip[c] ? FW'(MAG_POS_MAX) : FW'(dv_quo_r[DIV_STAGES][c]);
      end
    end
  end

  qvr_out_t out_data_nxt;

  always_comb begin
    if (dv_zq_r[DIV_STAGES]) begin
      out_data_nxt = '0;
      out_data_nxt.zero_quat = 1'b1;
    end else begin
      out_data_nxt.rot_x     = rot_nxt[0];
      out_data_nxt.rot_y     = rot_nxt[1];
      out_data_nxt.rot_z     = rot_nxt[2];
      out_data_nxt.zero_quat = 1'b0;
      out_data_nxt.saturated = |clip;
    end
  end

  logic     out_valid_r;
  qvr_out_t out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= dv_vld_r[DIV_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== hdl/qvr_checker.sv =====
// ----------------------------------------------------------------------------
// qvr_checker: port-level checks for the quaternion vector rotator
// Watches the start and result beats and the flag rules of the result.
// ----------------------------------------------------------------------------
module qvr_checker import qvr_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     start,
  input logic     busy,
  input qvr_in_t  in_data,
  input logic     out_valid,
  input qvr_out_t out_data
);

  // Every start beat gives its result after the fixed latency.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> ##LATENCY out_valid)
    else $error("start beat without a result after the pipeline latency");

  // No result beat appears without a start beat behind it.
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, LATENCY))
    else $error("result beat without a matching start beat");

  // A zero quaternion gives a zero vector and no saturation flag.
  a_zero_quat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.zero_quat |->
      out_data.rot_x == '0 && out_data.rot_y == '0 && out_data.rot_z == '0
      && !out_data.saturated)
    else $error("zero quaternion result is not clean");

  // A saturated result has at least one component at a bound.
  a_sat_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.saturated |->
      out_data.rot_x == 16'sh7fff || out_data.rot_x == -16'sh8000 ||
      out_data.rot_y == 16'sh7fff || out_data.rot_y == -16'sh8000 ||
      out_data.rot_z == 16'sh7fff || out_data.rot_z == -16'sh8000)
    else $error("saturation flag set with no component at a bound");

  // The input data is only read with start, so in_data needs no check.
  logic unused_in;
  assign unused_in = ^in_data ^ busy;

endmodule

bind quaternion_vector_rotate qvr_checker u_qvr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_data  (out_data)
);

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for quaternion_vector_rotate
// Drives quaternion/vector beats from a queue, predicts each rotated vector
// with wide integer math, and compares every result strobe in order.
// ----------------------------------------------------------------------------
module tb_top import qvr_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     start = 1'b0;
  logic     busy;
  qvr_in_t  in_data = '0;
  logic     out_valid;
  qvr_out_t out_data;

  qvr_in_t  pending_beats[$];
  qvr_out_t expected_rot[$];
  int       send_idle_pct = 0;
  bit       hold_send = 1'b0;
  bit       any_fail = 1'b0;

  quaternion_vector_rotate u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_data(in_data), .out_valid(out_valid), .out_data(out_data)
  );

  always #4 clk = ~clk;

  // Clamp a quotient to 16 bits and note whether it was clipped.
  function automatic logic signed [FW-1:0] clip16(longint q, inout bit sat);
    if (q > 32767) begin
      sat = 1'b1;
      return 16'sd32767;
    end
    if (q < -32768) begin
      sat = 1'b1;
      return -16'sd32768;
    end
    return q[FW-1:0];
  endfunction

  // Rotate v by q * (0, v) * conj(q) and divide by |q|^2, truncating.
  function automatic qvr_out_t rotate_vec(qvr_in_t b);
    qvr_out_t r;
    longint w, x, y, z, vx, vy, vz, den, tw, tx, ty, tz, rx, ry, rz;
    bit sat;
    w = b.quat_w; x = b.quat_x; y = b.quat_y; z = b.quat_z;
    vx = b.vec_x; vy = b.vec_y; vz = b.vec_z;
    r = '0;
    sat = 1'b0;
    den = w * w + x * x + y * y + z * z;
    if (den == 0) begin
      r.zero_quat = 1'b1;
      return r;
    end
    tw = -x * vx - y * vy - z * vz;
    tx = w * vx + y * vz - z * vy;
    ty = w * vy - x * vz + z * vx;
    tz = w * vz + x * vy - y * vx;
    rx = -tw * x + tx * w - ty * z + tz * y;
    ry = -tw * y + tx * z + ty * w - tz * x;
    rz = -tw * z - tx * y + ty * x + tz * w;
    // SystemVerilog integer division truncates toward zero.
    r.rot_x = clip16(rx / den, sat);
    r.rot_y = clip16(ry / den, sat);
    r.rot_z = clip16(rz / den, sat);
    r.saturated = sat;
    return r;
  endfunction

  // Pick a field value, biased toward the extremes and small magnitudes.
  function automatic logic [FW-1:0] pick16();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'(int'($urandom_range(0, 8)) - 4);
      3: return 16'h4000;
      4: return 16'hc000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic qvr_in_t mk_beat(int w, int x, int y, int z, int vx, int vy, int vz);
    qvr_in_t b;
    b.quat_w = 16'(w); b.quat_x = 16'(x); b.quat_y = 16'(y); b.quat_z = 16'(z);
    b.vec_x = 16'(vx); b.vec_y = 16'(vy); b.vec_z = 16'(vz);
    return b;
  endfunction

  // Driver: present the next beat whenever the sender is not idling.
  always @(posedge clk) begin
    if (rst_n && start && !busy) begin
      expected_rot.push_back(rotate_vec(in_data));
      void'(pending_beats.pop_front());
    end
    if (rst_n && !hold_send && pending_beats.size() > 0 &&
        ($urandom_range(0, 99) >= send_idle_pct)) begin
      start <= 1'b1;
      in_data <= pending_beats[0];
    end else begin
      start <= 1'b0;
    end
  end

  // Monitor: every strobe must match the oldest prediction.
  always @(posedge clk) begin
    qvr_out_t exp_r;
    if (rst_n && out_valid) begin
      if (expected_rot.size() == 0) begin
        $error("result beat with no prediction pending");
        any_fail = 1'b1;
      end else begin
        exp_r = expected_rot.pop_front();
        if (out_data.rot_x !== exp_r.rot_x) begin
          $error("rot_x exp %0d got %0d", exp_r.rot_x, out_data.rot_x);
          any_fail = 1'b1;
        end
        if (out_data.rot_y !== exp_r.rot_y) begin
          $error("rot_y exp %0d got %0d", exp_r.rot_y, out_data.rot_y);
          any_fail = 1'b1;
        end
        if (out_data.rot_z !== exp_r.rot_z) begin
          $error("rot_z exp %0d got %0d", exp_r.rot_z, out_data.rot_z);
          any_fail = 1'b1;
        end
        if (out_data.zero_quat !== exp_r.zero_quat) begin
          $error("zero_quat exp %0b got %0b", exp_r.zero_quat, out_data.zero_quat);
          any_fail = 1'b1;
        end
        if (out_data.saturated !== exp_r.saturated) begin
          $error("saturated exp %0b got %0b", exp_r.saturated, out_data.saturated);
          any_fail = 1'b1;
        end
      end
    end
  end

  // Wait until every queued beat is taken and every result has come back.
  task automatic drain();
    while (pending_beats.size() > 0 || start || expected_rot.size() > 0)
      @(posedge clk);
  endtask

  task automatic queue_random(int n);
    for (int i = 0; i < n; i++)
      pending_beats.push_back(mk_beat(pick16(), pick16(), pick16(), pick16(),
                                      pick16(), pick16(), pick16()));
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: zero quaternion, identity, axis turns, extremes, saturation.
    pending_beats.push_back(mk_beat(0, 0, 0, 0, 100, -200, 300));
    pending_beats.push_back(mk_beat(0, 0, 0, 0, 32767, -32768, 1));
    pending_beats.push_back(mk_beat(16384, 0, 0, 0, 1234, -5678, 32767));
    pending_beats.push_back(mk_beat(11585, 0, 0, 11585, 1000, 0, 0));
    pending_beats.push_back(mk_beat(0, 16384, 0, 0, 10, 20, 30));
    pending_beats.push_back(mk_beat(0, 0, 16384, 0, -32768, -32768, -32768));
    pending_beats.push_back(mk_beat(0, 0, 0, 16384, 32767, 32767, 32767));
    pending_beats.push_back(mk_beat(-32768, -32768, -32768, -32768, -32768, 32767, -1));
    pending_beats.push_back(mk_beat(32767, 32767, 32767, 32767, 32767, 32767, 32767));
    // Rotating a long diagonal toward the z axis overflows 16 bits.
    pending_beats.push_back(mk_beat(16384, 6786, -6786, 0, 32767, 32767, 0));
    pending_beats.push_back(mk_beat(1, 1, 0, 0, -32768, 32767, -32768));
    pending_beats.push_back(mk_beat(0, 0, 0, 1, 5, -7, 9));
    pending_beats.push_back(mk_beat(-1, 0, 0, 0, -1, -1, -1));
    pending_beats.push_back(mk_beat(3, -5, 7, -11, 13, -17, 19));
    pending_beats.push_back(mk_beat(-16384, 16384, -16384, 16384, 32767, -32768, 0));
    drain();

    // Hold the sender off while a batch is queued, then resume.
    hold_send = 1'b1;
    queue_random(20);
    repeat (5) @(posedge clk);
    hold_send = 1'b0;
    drain();

    send_idle_pct = 35;
    queue_random(600);
    drain();
    send_idle_pct = 60;
    queue_random(600);
    drain();
    send_idle_pct = 0;
    queue_random(560);
    drain();

    repeat (LATENCY + 10) @(posedge clk);
    if (!any_fail && expected_rot.size() == 0)
      $display("** quaternion_vector_rotate: PASSED **");
    else
      $display("** quaternion_vector_rotate: FAILED **");
    $finish;
  end

  // Watchdog against a hung handshake or a lost result.
  initial begin
    #2ms;
    $display("** quaternion_vector_rotate: FAILED **");
    $finish;
  end
endmodule
